// File: src/qfn_pkg.sv
// qfn_pkg: shared constants and types for the quad face normal block.
// Used by the sqrt cell, the divide cell and the top level.
// No dependencies.
package qfn_pkg;

  // Default coordinate width and the widths that follow from it
  localparam int COORD_BITS_DEF = 16;
  localparam int MAG_BITS_DEF   = 2 * (COORD_BITS_DEF + 1) + 1;
  localparam int ROOT_BITS_DEF  = MAG_BITS_DEF + 1;

  // Quotient bits per component (result magnitude is at most 32767)
  localparam int QBITS       = 15;
  localparam int SCALE_SHIFT = 15;
  localparam int NORM_BITS   = 16;

  // Per-stage control that travels down the cell chain
  typedef struct packed {
    logic       valid;
    logic       degen;
    logic [2:0] neg;
  } qfn_flags_t;

endpackage

// File: src/quad_face_normal.sv
// quad_face_normal: unit normal of a quadrilateral from its four corners.
// Depends on qfn_pkg, qfn_sqrt_cell and qfn_div_cell.
//
//   channel  direction  handshake            payload
//   in_      input      in_valid / in_stall  in_c{0..3}_{x,y,z}
//   out_     output     out_valid/out_stall  out_norm_{x,y,z}, out_degenerate
//   cfg_     input      cfg_valid/cfg_ready  cfg_ccw_order
//
// One request per cycle sustained while in_stall is low. The pipeline runs
// through the front stages, one sqrt cell per root bit, the numerator stage,
// fifteen divide cells and the output register. The whole chain advances
// together; a skid register behind the output register lets one extra result
// land while the output is stalled, and in_stall rises only while the skid is full.
// Synchronous active-low reset clears all valid bits and sets ccw_order to 1.
module quad_face_normal import qfn_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [COORD_BITS-1:0]        in_c0_x,
  input  logic [COORD_BITS-1:0]        in_c0_y,
  input  logic [COORD_BITS-1:0]        in_c0_z,
  input  logic [COORD_BITS-1:0]        in_c1_x,
  input  logic [COORD_BITS-1:0]        in_c1_y,
  input  logic [COORD_BITS-1:0]        in_c1_z,
  input  logic [COORD_BITS-1:0]        in_c2_x,
  input  logic [COORD_BITS-1:0]        in_c2_y,
  input  logic [COORD_BITS-1:0]        in_c2_z,
  input  logic [COORD_BITS-1:0]        in_c3_x,
  input  logic [COORD_BITS-1:0]        in_c3_y,
  input  logic [COORD_BITS-1:0]        in_c3_z,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [NORM_BITS-1:0]  out_norm_x,
  output logic signed [NORM_BITS-1:0]  out_norm_y,
  output logic signed [NORM_BITS-1:0]  out_norm_z,
  output logic                         out_degenerate,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic                         cfg_ccw_order
);

  localparam int CB  = COORD_BITS;
  localparam int D   = CB + 1;          // edge diagonal width
  localparam int PW  = 2 * D;           // partial product width
  localparam int M   = 2 * D + 1;       // cross component / |s| width
  localparam int H   = D + 1;           // low half of |s| for squaring
  localparam int SQW = 2 * M;
  localparam int R   = M + 1;           // root bits
  localparam int SW  = 2 * R;           // sum of squares width
  localparam int RW  = R + 3;
  localparam int NW  = M + QBITS;

  // Config register
  logic ccw_r;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ccw_r <= 1'b1;
    end else if (cfg_valid) begin
      ccw_r <= cfg_ccw_order;
    end
  end

  // Chain enable: frozen only while the skid holds a result
  logic en;
  logic skid_valid_r;
  assign en       = !skid_valid_r;
  assign in_stall = skid_valid_r;

  // Stage 1: diagonals d1 = c2 - c0, d2 = c3 - c1
  qfn_flags_t             f1_r, f2_r, f3_r, f4_r, f5_r, f6_r, f7_r, f8_r;
  logic signed [D-1:0]    d1_r [3];
  logic signed [D-1:0]    d2_r [3];

  always_ff @(posedge clk) begin
    if (en) begin
      d1_r[0] <= $signed({in_c2_x[CB-1], in_c2_x}) - $signed({in_c0_x[CB-1], in_c0_x});
      d1_r[1] <= $signed({in_c2_y[CB-1], in_c2_y}) - $signed({in_c0_y[CB-1], in_c0_y});
      d1_r[2] <= $signed({in_c2_z[CB-1], in_c2_z}) - $signed({in_c0_z[CB-1], in_c0_z});
      d2_r[0] <= $signed({in_c3_x[CB-1], in_c3_x}) - $signed({in_c1_x[CB-1], in_c1_x});
      d2_r[1] <= $signed({in_c3_y[CB-1], in_c3_y}) - $signed({in_c1_y[CB-1], in_c1_y});
      d2_r[2] <= $signed({in_c3_z[CB-1], in_c3_z}) - $signed({in_c1_z[CB-1], in_c1_z});
    end
  end

  // Stage 2: six partial products of d1 x d2
  logic signed [PW-1:0] p_r [6];

  always_ff @(posedge clk) begin
    if (en) begin
      p_r[0] <= d1_r[1] * d2_r[2];
      p_r[1] <= d1_r[2] * d2_r[1];
      p_r[2] <= d1_r[2] * d2_r[0];
      p_r[3] <= d1_r[0] * d2_r[2];
      p_r[4] <= d1_r[0] * d2_r[1];
      p_r[5] <= d1_r[1] * d2_r[0];
    end
  end

  // Stage 3: cross product components (summed normal is twice this)
  logic signed [M-1:0] c_r [3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        c_r[k] <= M'(p_r[2*k]) - M'(p_r[2*k+1]);
      end
    end
  end

  // Stage 4: |s| = 2|c|, sign flips when corners are reversed
  logic [M-1:0]   mag4_r [3];
  logic [M-1:0]   c_abs  [3];
  qfn_flags_t     f4_nxt;

  always_comb begin
    f4_nxt       = f3_r;
    f4_nxt.degen = (c_r[0] == '0) && (c_r[1] == '0) && (c_r[2] == '0);
    for (int k = 0; k < 3; k++) begin
      c_abs[k]      = c_r[k][M-1] ? M'(-c_r[k]) : M'(c_r[k]);
      f4_nxt.neg[k] = c_r[k][M-1] ^ f3_r.neg[k];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        mag4_r[k] <= {c_abs[k][M-2:0], 1'b0};
      end
    end
  end

  // Stage 5: split squares of |s| into half-width products
  logic [2*D-1:0]  hh_r [3];
  logic [D+H-1:0]  hl_r [3];
  logic [2*H-1:0]  ll_r [3];
  logic [M-1:0]    mag5_r [3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        hh_r[k]   <= (2*D)'(mag4_r[k][M-1:H]) * (2*D)'(mag4_r[k][M-1:H]);
        hl_r[k]   <= (D+H)'(mag4_r[k][M-1:H]) * (D+H)'(mag4_r[k][H-1:0]);
        ll_r[k]   <= (2*H)'(mag4_r[k][H-1:0]) * (2*H)'(mag4_r[k][H-1:0]);
        mag5_r[k] <= mag4_r[k];
      end
    end
  end

  // Stage 6: recombine each square
  logic [SQW-1:0] sq_r [3];
  logic [M-1:0]   mag6_r [3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        sq_r[k]   <= (SQW'(hh_r[k]) << (2*H)) + (SQW'(hl_r[k]) << (H+1)) + SQW'(ll_r[k]);
        mag6_r[k] <= mag5_r[k];
      end
    end
  end

  // Stage 7: sum of squares
  logic [SW-1:0]  sum_r;
  logic [3*M-1:0] mag7_r;

  always_ff @(posedge clk) begin
    if (en) begin
      sum_r  <= SW'(sq_r[0]) + SW'(sq_r[1]) + SW'(sq_r[2]);
      mag7_r <= {mag6_r[2], mag6_r[1], mag6_r[0]};
    end
  end

  // Front-stage control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_r <= '0;
      f2_r <= '0;
      f3_r <= '0;
      f4_r <= '0;
      f5_r <= '0;
      f6_r <= '0;
      f7_r <= '0;
    end else if (en) begin
      f1_r <= '{valid: in_valid, degen: 1'b0, neg: {3{!ccw_r}}};
      f2_r <= f1_r;
      f3_r <= f2_r;
      f4_r <= f4_nxt;
      f5_r <= f4_r;
      f6_r <= f5_r;
      f7_r <= f6_r;
    end
  end

  // Square root chain, one cell per root bit
  qfn_flags_t      sq_flags [R+1];
  logic [SW-1:0]   sq_rad   [R+1];
  logic [RW-1:0]   sq_rem   [R+1];
  logic [R-1:0]    sq_root  [R+1];
  logic [3*M-1:0]  sq_mag   [R+1];

  assign sq_flags[0] = f7_r;
  assign sq_rad[0]   = sum_r;
  assign sq_rem[0]   = '0;
  assign sq_root[0]  = '0;
  assign sq_mag[0]   = mag7_r;

  for (genvar g = 0; g < R; g++) begin : g_sqrt
    qfn_sqrt_cell #(.R(R), .M(M)) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .flags_i (sq_flags[g]),
      .rad_i   (sq_rad[g]),
      .rem_i   (sq_rem[g]),
      .root_i  (sq_root[g]),
      .mag_i   (sq_mag[g]),
      .flags_o (sq_flags[g+1]),
      .rad_o   (sq_rad[g+1]),
      .rem_o   (sq_rem[g+1]),
      .root_o  (sq_root[g+1]),
      .mag_o   (sq_mag[g+1])
    );
  end

  // Stage 8: numerators |s| * 32767
  logic [R-1:0]    len8_r;
  logic [3*NW-1:0] num8_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f8_r <= '0;
    end else if (en) begin
      f8_r <= sq_flags[R];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      len8_r <= sq_root[R];
      for (int k = 0; k < 3; k++) begin
        num8_r[k*NW +: NW] <= (NW'(sq_mag[R][k*M +: M]) << SCALE_SHIFT)
                              - NW'(sq_mag[R][k*M +: M]);
      end
    end
  end

  // Divide chain, one cell per quotient bit, MSB first
  qfn_flags_t          dv_flags [QBITS+1];
  logic [R-1:0]        dv_len   [QBITS+1];
  logic [3*NW-1:0]     dv_rem   [QBITS+1];
  logic [3*QBITS-1:0]  dv_quo   [QBITS+1];

  assign dv_flags[0] = f8_r;
  assign dv_len[0]   = len8_r;
  assign dv_rem[0]   = num8_r;
  assign dv_quo[0]   = '0;

  for (genvar j = 0; j < QBITS; j++) begin : g_div
    qfn_div_cell #(.R(R), .M(M), .BIT(QBITS - 1 - j)) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .flags_i (dv_flags[j]),
      .len_i   (dv_len[j]),
      .rem_i   (dv_rem[j]),
      .quo_i   (dv_quo[j]),
      .flags_o (dv_flags[j+1]),
      .len_o   (dv_len[j+1]),
      .rem_o   (dv_rem[j+1]),
      .quo_o   (dv_quo[j+1])
    );
  end

  // Sign and degenerate handling of the finished result
  qfn_flags_t                  fin;
  logic [3*NORM_BITS-1:0]      res;
  logic [NORM_BITS-1:0]        qext [3];

  assign fin = dv_flags[QBITS];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      qext[k] = {1'b0, dv_quo[QBITS][k*QBITS +: QBITS]};
      if (fin.degen) begin
        res[k*NORM_BITS +: NORM_BITS] = '0;
      end else if (fin.neg[k]) begin
        res[k*NORM_BITS +: NORM_BITS] = -qext[k];
      end else begin
        res[k*NORM_BITS +: NORM_BITS] = qext[k];
      end
    end
  end

  // Output register with skid
  logic                      out_valid_r;
  logic [3*NORM_BITS-1:0]    out_res_r, skid_res_r;
  logic                      out_deg_r, skid_deg_r;
  logic                      take, push;

  assign take = out_valid_r && !out_stall;
  assign push = en && fin.valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || take) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r  <= push;
      end
    end else if (push) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || take) begin
      if (skid_valid_r) begin
        out_res_r <= skid_res_r;
        out_deg_r <= skid_deg_r;
      end else begin
        out_res_r <= res;
        out_deg_r <= fin.degen;
      end
    end else if (push) begin
      skid_res_r <= res;
      skid_deg_r <= fin.degen;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_norm_x     = out_res_r[0*NORM_BITS +: NORM_BITS];
  assign out_norm_y     = out_res_r[1*NORM_BITS +: NORM_BITS];
  assign out_norm_z     = out_res_r[2*NORM_BITS +: NORM_BITS];
  assign out_degenerate = out_deg_r;

`ifndef ASSERT_OFF
  // Skid only fills behind a held output
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid full while output empty");

  // Degenerate result carries a zero vector
  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_deg_r) |-> (out_res_r == '0))
    else $error("degenerate result with nonzero normal");

  // Components stay within +-32767
  a_norm_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_res_r[NORM_BITS-1:0] != 16'h8000 &&
                     out_res_r[2*NORM_BITS-1:NORM_BITS] != 16'h8000 &&
                     out_res_r[3*NORM_BITS-1:2*NORM_BITS] != 16'h8000))
    else $error("normal component out of range");
`endif

endmodule

// File: src/qfn_sqrt_cell.sv
// qfn_sqrt_cell: one cell of the square root chain, resolves one root bit.
// Radix-2 restoring digit recurrence; carries the component magnitudes along.
// Depends on qfn_pkg.
module qfn_sqrt_cell import qfn_pkg::*; #(
  parameter int R = ROOT_BITS_DEF,
  parameter int M = MAG_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  qfn_flags_t         flags_i,
  input  logic [2*R-1:0]     rad_i,
  input  logic [R+2:0]       rem_i,
  input  logic [R-1:0]       root_i,
  input  logic [3*M-1:0]     mag_i,
  output qfn_flags_t         flags_o,
  output logic [2*R-1:0]     rad_o,
  output logic [R+2:0]       rem_o,
  output logic [R-1:0]       root_o,
  output logic [3*M-1:0]     mag_o
);

  localparam int SW = 2 * R;
  localparam int RW = R + 3;

  qfn_flags_t      flags_r;
  logic [SW-1:0]   rad_r;
  logic [RW-1:0]   rem_r, rem_nxt;
  logic [R-1:0]    root_r, root_nxt;
  logic [3*M-1:0]  mag_r;
  logic [RW-1:0]   rem_sh, trial;
  logic            ge;

  // Bring down the next two radicand bits and try root*4+1
  always_comb begin
    rem_sh   = {rem_i[RW-3:0], rad_i[SW-1 -: 2]};
    trial    = {1'b0, root_i, 2'b01};
    ge       = (rem_sh >= trial);
    rem_nxt  = ge ? (rem_sh - trial) : rem_sh;
    root_nxt = {root_i[R-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r <= '0;
    end else if (en) begin
      flags_r <= flags_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rad_r  <= {rad_i[SW-3:0], 2'b00};
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
      mag_r  <= mag_i;
    end
  end

  assign flags_o = flags_r;
  assign rad_o   = rad_r;
  assign rem_o   = rem_r;
  assign root_o  = root_r;
  assign mag_o   = mag_r;

endmodule

// File: src/qfn_div_cell.sv
// qfn_div_cell: one cell of the scaling divider, resolves quotient bit BIT
// for all three components against the shared length.
// Depends on qfn_pkg.
module qfn_div_cell import qfn_pkg::*; #(
  parameter int R   = ROOT_BITS_DEF,
  parameter int M   = MAG_BITS_DEF,
  parameter int BIT = QBITS - 1
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  qfn_flags_t              flags_i,
  input  logic [R-1:0]            len_i,
  input  logic [3*(M+QBITS)-1:0]  rem_i,
  input  logic [3*QBITS-1:0]      quo_i,
  output qfn_flags_t              flags_o,
  output logic [R-1:0]            len_o,
  output logic [3*(M+QBITS)-1:0]  rem_o,
  output logic [3*QBITS-1:0]      quo_o
);

  localparam int NW = M + QBITS;
  localparam int CW = R + QBITS;

  qfn_flags_t             flags_r;
  logic [R-1:0]           len_r;
  logic [3*NW-1:0]        rem_r, rem_nxt;
  logic [3*QBITS-1:0]     quo_r, quo_nxt;
  logic [CW-1:0]          shl_len;
  logic [CW-1:0]          rem_ext [3];
  logic [2:0]             ge;

  // Restoring step: subtract len << BIT where it fits
  always_comb begin
    shl_len = CW'(len_i) << BIT;
    rem_nxt = rem_i;
    quo_nxt = quo_i;
    for (int k = 0; k < 3; k++) begin
      rem_ext[k] = CW'(rem_i[k*NW +: NW]);
      ge[k]      = (shl_len <= rem_ext[k]);
      if (ge[k]) begin
        rem_nxt[k*NW +: NW]      = NW'(rem_ext[k] - shl_len);
        quo_nxt[k*QBITS + BIT]   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r <= '0;
    end else if (en) begin
      flags_r <= flags_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      len_r <= len_i;
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign flags_o = flags_r;
  assign len_o   = len_r;
  assign rem_o   = rem_r;
  assign quo_o   = quo_r;

endmodule
